// ===== sv/chme_pkg.sv =====
package chme_pkg;

  // fixed field widths
  localparam int KEY_W      = 64;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 11;
  localparam int CFG_W      = 4;

  // default sizing
  localparam int DEF_ENTRIES         = 1024;
  localparam int DEF_MAX_BUCKET_BITS = 10;
  localparam int DEF_VALUE_BITS      = 32;

  localparam logic [CFG_W-1:0] BUCKET_BITS_RST = CFG_W'(10);

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_MULTI  = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    action_e              action;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value_in;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [VALUE_W-1:0]   value_out;
    logic [COUNT_W-1:0]   entries_used;
  } rsp_t;

  typedef logic [CFG_W-1:0] cfg_t;

endpackage

// ===== sv/chme_stream_if.sv =====
interface chme_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/chme_ram.sv =====
module chme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/chained_hash_map_engine_core.sv =====
// channel | dir | payload                                        | handshake
// req_i   | in  | action, key, value_in                          | valid/ready
// rsp_o   | out | status, found, value_out, entries_used         | valid/ready
// cfg_i   | in  | bucket_bits                                    | valid/ready
//
// one request at a time: after accept the bucket head is read (S_HEAD_RD, S_HEAD_DAT),
// then each chain link compared takes S_WALK and S_CMP, with a final S_WALK when the walk
// ends without a match, then S_EXEC (and S_LINK for an update) and S_DONE posts the result
// a remove that moves the last entry adds S_COPY_RD, S_COPY_WR and the pointer redirect
// sweeps over the head and link memories
// after reset a clearing pass writes the empty marker into all 2^MAX_BUCKET_BITS heads
// a stalled response holds in the output register; req_i is ready only when idle
module chained_hash_map_engine_core #(
  parameter int ENTRIES         = chme_pkg::DEF_ENTRIES,
  parameter int MAX_BUCKET_BITS = chme_pkg::DEF_MAX_BUCKET_BITS,
  parameter int VALUE_BITS      = chme_pkg::DEF_VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  chme_stream_if.sink   req_i,
  chme_stream_if.source rsp_o,
  chme_stream_if.sink   cfg_i
);
  localparam int BUCKETS = 1 << MAX_BUCKET_BITS;
  localparam int BW      = MAX_BUCKET_BITS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW      = $clog2(ENTRIES + 1);
  localparam int SWPW    = ((BW > AW) ? BW : AW) + 1;

  localparam logic [SW-1:0]   NIL       = SW'(ENTRIES);
  localparam logic [SWPW-1:0] BUCKETS_L = SWPW'(BUCKETS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD_RD, S_HEAD_DAT, S_WALK, S_CMP, S_EXEC,
    S_LINK, S_COPY_RD, S_COPY_WR, S_SWP_HEAD, S_SWP_NEXT, S_DONE
  } state_e;

  state_e                        state_q, state_d;
  logic [SWPW-1:0]               swp_q, swp_d;
  logic                          pend_q, pend_d;
  logic [SWPW-1:0]               pend_addr_q, pend_addr_d;
  chme_pkg::action_e             act_q, act_d;
  logic [chme_pkg::KEY_W-1:0]    key_q, key_d;
  logic [VALUE_BITS-1:0]         val_q, val_d;
  logic [BW-1:0]                 bucket_q, bucket_d;
  logic [SW-1:0]                 cur_q, cur_d;
  logic [SW-1:0]                 prev_q, prev_d;
  logic [SW-1:0]                 hit_q, hit_d;
  logic [SW-1:0]                 hitnext_q, hitnext_d;
  logic [SW-1:0]                 link_tgt_q, link_tgt_d;
  logic [SW-1:0]                 steps_q, steps_d;
  logic                          found_q, found_d;
  logic [VALUE_BITS-1:0]         vout_q, vout_d;
  chme_pkg::status_e             status_q, status_d;
  logic [SW-1:0]                 cnt_q, cnt_d;
  chme_pkg::cfg_t                bb_q;
  logic                          rsp_valid_q, rsp_valid_d;
  chme_pkg::rsp_t                rsp_q, rsp_d;

  // memory ports
  logic                          head_we;
  logic [BW-1:0]                 head_waddr, head_raddr;
  logic [SW-1:0]                 head_wdata, head_rdata;
  logic                          key_we, value_we, next_we;
  logic [AW-1:0]                 ent_waddr, next_waddr, ent_raddr;
  logic [chme_pkg::KEY_W-1:0]    key_wdata, key_rdata;
  logic [VALUE_BITS-1:0]         value_wdata, value_rdata;
  logic [SW-1:0]                 next_wdata, next_rdata;

  // bucket index from the request key under the current setting
  logic [4:0]                    bits_eff;
  logic [BW-1:0]                 bmask;
  logic [63:0]                   val_in64;
  logic [63:0]                   vout64;
  logic [31:0]                   cnt32;
  logic                          full;

  assign bits_eff = ({1'b0, bb_q} > 5'(MAX_BUCKET_BITS)) ? 5'(MAX_BUCKET_BITS)
                                                         : {1'b0, bb_q};
  always_comb begin
    for (int j = 0; j < BW; j++) begin
      bmask[j] = (j < int'(bits_eff));
    end
  end

  assign val_in64 = 64'(req_i.payload.value_in);
  assign vout64   = 64'(vout_q);
  assign cnt32    = 32'(cnt_q);
  assign full     = (cnt_q == NIL);

  assign req_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  chme_ram #(.WIDTH(SW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  chme_ram #(.WIDTH(chme_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(ent_waddr), .wdata_i(key_wdata),
    .raddr_i(ent_raddr), .rdata_o(key_rdata)
  );
  chme_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_value_ram (
    .clk_i, .we_i(value_we), .waddr_i(ent_waddr), .wdata_i(value_wdata),
    .raddr_i(ent_raddr), .rdata_o(value_rdata)
  );
  chme_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(ent_raddr), .rdata_o(next_rdata)
  );

  // sequencer: clear, walk, update, redirect sweeps, response
  always_comb begin
    state_d     = state_q;
    swp_d       = swp_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    bucket_d    = bucket_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    hit_d       = hit_q;
    hitnext_d   = hitnext_q;
    link_tgt_d  = link_tgt_q;
    steps_d     = steps_q;
    found_d     = found_q;
    vout_d      = vout_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;

    head_we     = 1'b0;
    head_waddr  = bucket_q;
    head_wdata  = link_tgt_q;
    head_raddr  = bucket_q;
    key_we      = 1'b0;
    value_we    = 1'b0;
    next_we     = 1'b0;
    ent_waddr   = cnt_q[AW-1:0];
    next_waddr  = cnt_q[AW-1:0];
    ent_raddr   = cur_q[AW-1:0];
    key_wdata   = key_q;
    value_wdata = val_q;
    next_wdata  = NIL;

    // response register drains independently of the sequencer
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = swp_q[BW-1:0];
        head_wdata = NIL;
        swp_d      = swp_q + SWPW'(1);
        if (swp_q == BUCKETS_L - SWPW'(1)) begin
          swp_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          act_d    = req_i.payload.action;
          key_d    = req_i.payload.key;
          val_d    = val_in64[VALUE_BITS-1:0];
          bucket_d = req_i.payload.key[BW-1:0] & bmask;
          state_d  = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        head_raddr = bucket_q;
        state_d    = S_HEAD_DAT;
      end
      S_HEAD_DAT: begin
        cur_d    = head_rdata;
        prev_d   = NIL;
        hit_d    = NIL;
        steps_d  = '0;
        found_d  = 1'b0;
        vout_d   = '0;
        status_d = chme_pkg::ST_DONE;
        state_d  = S_WALK;
      end
      S_WALK: begin
        // stop at the empty marker, a stale slot, or the step bound
        if ((cur_q < cnt_q) && (steps_q < NIL)) begin
          ent_raddr = cur_q[AW-1:0];
          state_d   = S_CMP;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_CMP: begin
        if (key_rdata == key_q) begin
          found_d   = 1'b1;
          hit_d     = cur_q;
          hitnext_d = next_rdata;
          vout_d    = value_rdata;
          state_d   = S_EXEC;
        end else begin
          prev_d  = cur_q;
          cur_d   = next_rdata;
          steps_d = steps_q + SW'(1);
          state_d = S_WALK;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (act_q != chme_pkg::ACT_LOOKUP) begin
          vout_d = '0;
        end
        unique case (act_q)
          chme_pkg::ACT_SET: begin
            if (found_q) begin
              value_we  = 1'b1;
              ent_waddr = hit_q[AW-1:0];
            end else if (full) begin
              status_d = chme_pkg::ST_FULL;
            end else begin
              key_we     = 1'b1;
              value_we   = 1'b1;
              next_we    = 1'b1;
              next_wdata = NIL;
              link_tgt_d = cnt_q;
              state_d    = S_LINK;
            end
          end
          chme_pkg::ACT_MULTI: begin
            if (full) begin
              status_d = chme_pkg::ST_FULL;
            end else begin
              // new entry goes just ahead of the first match, or at the chain end if none
              key_we     = 1'b1;
              value_we   = 1'b1;
              next_we    = 1'b1;
              next_wdata = hit_q;
              link_tgt_d = cnt_q;
              state_d    = S_LINK;
            end
          end
          chme_pkg::ACT_LOOKUP: begin
            if (!found_q) begin
              status_d = chme_pkg::ST_NOT_FOUND;
            end
          end
          chme_pkg::ACT_REMOVE: begin
            if (!found_q) begin
              status_d = chme_pkg::ST_NOT_FOUND;
            end else begin
              link_tgt_d = hitnext_q;
              state_d    = S_LINK;
            end
          end
          default: ;
        endcase
      end
      S_LINK: begin
        // point the predecessor (or the head) at the link target
        if (prev_q == NIL) begin
          head_we    = 1'b1;
          head_waddr = bucket_q;
          head_wdata = link_tgt_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_q[AW-1:0];
          next_wdata = link_tgt_q;
        end
        if (act_q == chme_pkg::ACT_REMOVE) begin
          cnt_d = cnt_q - SW'(1);
          if (hit_q != cnt_q - SW'(1)) begin
            state_d = S_COPY_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cnt_d   = cnt_q + SW'(1);
          state_d = S_DONE;
        end
      end
      S_COPY_RD: begin
        // last dense entry, already relinked above if it was the predecessor
        ent_raddr = cnt_q[AW-1:0];
        state_d   = S_COPY_WR;
      end
      S_COPY_WR: begin
        key_we      = 1'b1;
        value_we    = 1'b1;
        next_we     = 1'b1;
        ent_waddr   = hit_q[AW-1:0];
        next_waddr  = hit_q[AW-1:0];
        key_wdata   = key_rdata;
        value_wdata = value_rdata;
        next_wdata  = next_rdata;
        swp_d       = '0;
        pend_d      = 1'b0;
        state_d     = S_SWP_HEAD;
      end
      S_SWP_HEAD: begin
        // read one head per cycle, rewrite the previous one if it named the moved slot
        if (pend_q && (head_rdata == cnt_q)) begin
          head_we    = 1'b1;
          head_waddr = pend_addr_q[BW-1:0];
          head_wdata = hit_q;
        end
        if (swp_q < BUCKETS_L) begin
          head_raddr  = swp_q[BW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = swp_q;
          swp_d       = swp_q + SWPW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            swp_d   = '0;
            state_d = S_SWP_NEXT;
          end
        end
      end
      S_SWP_NEXT: begin
        if (pend_q && (next_rdata == cnt_q)) begin
          next_we    = 1'b1;
          next_waddr = pend_addr_q[AW-1:0];
          next_wdata = hit_q;
        end
        if (swp_q < SWPW'(cnt_q)) begin
          ent_raddr   = swp_q[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = swp_q;
          swp_d       = swp_q + SWPW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            swp_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d        = 1'b1;
          rsp_d.status       = status_q;
          rsp_d.found        = found_q;
          rsp_d.value_out    = vout64[chme_pkg::VALUE_W-1:0];
          rsp_d.entries_used = cnt32[chme_pkg::COUNT_W-1:0];
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      swp_q       <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      bb_q        <= chme_pkg::BUCKET_BITS_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      swp_q       <= swp_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        bb_q <= cfg_i.payload;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    act_q       <= act_d;
    key_q       <= key_d;
    val_q       <= val_d;
    bucket_q    <= bucket_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    hit_q       <= hit_d;
    hitnext_q   <= hitnext_d;
    link_tgt_q  <= link_tgt_d;
    steps_q     <= steps_d;
    found_q     <= found_d;
    vout_q      <= vout_d;
    status_q    <= status_d;
    rsp_q       <= rsp_d;
  end
endmodule
